/* rtl/sbmq_pkg.sv */
`default_nettype none

package sbmq_pkg;

  // operation codes of the cmd field
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // request transaction
  typedef struct packed {
    logic               cmd;
    logic [1:0]         queue_index;
    logic signed [31:0] push_value;
  } req_t;

  // result transaction
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] pop_value;
  } rsp_t;

  // classified operation passed from front to back
  typedef struct packed {
    logic        pop;
    logic [1:0]  q;
    logic [31:0] value;
  } op_t;

endpackage

`default_nettype wire

/* rtl/shared_buffer_multi_queue_unit.sv */
`default_nettype none

// channel   | ports                  | transfer
// ----------+------------------------+-------------------------------------
// request   | start, busy, req_i     | taken when start is high, busy low
// result    | done_o, rsp_o          | one cycle strobe, always taken
//
// the back end reads the pointers as it takes a transaction from the
// front queue; a push then updates link and data and registers its
// result together, while a pop first reads link and data and then
// relinks as it registers its result; the head pointer read must
// finish before the link and data reads
// the back end takes no new transaction until it has finished the last
// the front queue holds two requests, busy rises when both are taken
// no clearing pass after reset: a high-water mark stands in for the
// initial slot chain of the link store
// results cannot be held off by the receiver

module shared_buffer_multi_queue_unit #(
  parameter int SLOTS     = 64,
  parameter int QUEUES    = 4,
  parameter int DATA_BITS = 32
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  input  sbmq_pkg::req_t      req_i,
  output logic                busy,
  output logic                done_o,
  output sbmq_pkg::rsp_t      rsp_o
);

  // classified operations waiting for the back end
  logic          op_valid;
  logic          op_take;
  sbmq_pkg::op_t op;

  // front end: accept transaction, fold queue index, buffer it
  sbmq_front #(
    .QUEUES (QUEUES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_i      (req_i),
    .busy_o     (busy),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_take_i  (op_take)
  );

  // back end: linked-list sequencer over data, link and pointer stores
  sbmq_back #(
    .SLOTS     (SLOTS),
    .QUEUES    (QUEUES),
    .DATA_BITS (DATA_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_take_o  (op_take),
    .done_o     (done_o),
    .rsp_o      (rsp_o)
  );

endmodule

`default_nettype wire

/* rtl/sbmq_front.sv */
`default_nettype none

module sbmq_front #(
  parameter int QUEUES = 4
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  sbmq_pkg::req_t      req_i,
  output logic                busy_o,
  output logic                op_valid_o,
  output sbmq_pkg::op_t       op_o,
  input  wire                 op_take_i
);

  sbmq_pkg::op_t fifo_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic [1:0]    q_mod;
  logic          accept;
  sbmq_pkg::op_t op_new;

  // fold queue index into range, at most three subtractions on two bits
  always_comb begin
    q_mod = req_i.queue_index;
    for (int k = 0; k < 3; k++) begin
      if (int'(q_mod) >= QUEUES) begin
        q_mod = q_mod - 2'(QUEUES);
      end
    end
  end

  always_comb begin
    op_new.pop   = (req_i.cmd == sbmq_pkg::CMD_POP);
    op_new.q     = q_mod;
    op_new.value = req_i.push_value;
  end

  assign busy_o     = (cnt_q == 2'd2);
  assign accept     = start_i && !busy_o;
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fifo_q[wr_ptr_q] <= op_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (op_take_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (accept && !op_take_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!accept && op_take_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/sbmq_back.sv */
`default_nettype none

module sbmq_back #(
  parameter int SLOTS     = 64,
  parameter int QUEUES    = 4,
  parameter int DATA_BITS = 32
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 op_valid_i,
  input  sbmq_pkg::op_t       op_i,
  output logic                op_take_o,
  output logic                done_o,
  output sbmq_pkg::rsp_t      rsp_o
);

  localparam int SW = $clog2(SLOTS);
  localparam int HW = SW + 1;
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int SB = (DATA_BITS < 32) ? DATA_BITS : 32;
  localparam int LW = SW + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;

  // memories
  logic [SB-1:0] data_mem [SLOTS];
  logic [LW-1:0] link_mem [SLOTS];
  logic [SW-1:0] head_mem [QUEUES];
  logic [SW-1:0] tail_mem [QUEUES];

  logic [1:0]          state_q, state_d;
  sbmq_pkg::op_t       op_q;
  logic [QUEUES-1:0]   head_vld_q, head_vld_d;
  logic                free_vld_q, free_vld_d;
  logic [SW-1:0]       free_idx_q, free_idx_d;
  logic [HW-1:0]       hwm_q, hwm_d;
  logic                done_q, done_d;
  sbmq_pkg::rsp_t      rsp_q, rsp_d;

  logic [SW-1:0]       head_rd_q, tail_rd_q;
  logic [LW-1:0]       link_rd_q;
  logic [SB-1:0]       data_rd_q;

  logic                pt_ren, link_ren, data_ren;
  logic [SW-1:0]       link_raddr;
  logic                link_we, data_we, head_we, tail_we;
  logic [SW-1:0]       link_waddr;
  logic [LW-1:0]       link_wdata;
  logic [SW-1:0]       head_wdata;

  logic [QW-1:0]       q_cur, q_new;
  logic                hv;
  logic                fresh;
  logic [HW-1:0]       nxt_ext;
  logic signed [SB-1:0] data_s;

  assign q_cur   = QW'(op_q.q);
  assign q_new   = QW'(op_i.q);
  assign hv      = head_vld_q[q_cur];
  assign fresh   = ({1'b0, free_idx_q} == hwm_q);
  assign nxt_ext = {1'b0, free_idx_q} + HW'(1);
  assign data_s  = data_rd_q;

  assign op_take_o = (state_q == ST_IDLE) && op_valid_i;
  assign done_o    = done_q;
  assign rsp_o     = rsp_q;

  always_comb begin
    state_d    = state_q;
    head_vld_d = head_vld_q;
    free_vld_d = free_vld_q;
    free_idx_d = free_idx_q;
    hwm_d      = hwm_q;
    done_d     = 1'b0;
    rsp_d.status    = sbmq_pkg::STAT_OK;
    rsp_d.pop_value = '0;
    pt_ren     = 1'b0;
    link_ren   = 1'b0;
    data_ren   = 1'b0;
    link_raddr = free_idx_q;
    link_we    = 1'b0;
    link_waddr = tail_rd_q;
    link_wdata = {1'b1, free_idx_q};
    data_we    = 1'b0;
    head_we    = 1'b0;
    head_wdata = free_idx_q;
    tail_we    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (op_valid_i) begin
          // fetch head, tail and the free slot's link together
          pt_ren   = 1'b1;
          link_ren = 1'b1;
          state_d  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!op_q.pop) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
          if (!free_vld_q) begin
            rsp_d.status = sbmq_pkg::STAT_FULL;
          end else begin
            data_we = 1'b1;
            tail_we = 1'b1;
            if (hv) begin
              link_we = 1'b1;
            end else begin
              head_we = 1'b1;
              head_vld_d[q_cur] = 1'b1;
            end
            if (fresh) begin
              // untouched slot, link is the next slot
              free_vld_d = (nxt_ext < HW'(SLOTS));
              free_idx_d = nxt_ext[SW-1:0];
              hwm_d      = hwm_q + HW'(1);
            end else begin
              free_vld_d = link_rd_q[SW];
              free_idx_d = link_rd_q[SW-1:0];
            end
          end
        end else begin
          if (!hv) begin
            done_d       = 1'b1;
            rsp_d.status = sbmq_pkg::STAT_EMPTY;
            state_d      = ST_IDLE;
          end else begin
            link_ren   = 1'b1;
            data_ren   = 1'b1;
            link_raddr = head_rd_q;
            state_d    = ST_POP;
          end
        end
      end
      ST_POP: begin
        done_d          = 1'b1;
        rsp_d.pop_value = 32'(data_s);
        if (head_rd_q == tail_rd_q) begin
          head_vld_d[q_cur] = 1'b0;
        end else begin
          head_we    = 1'b1;
          head_wdata = link_rd_q[SW-1:0];
        end
        link_we    = 1'b1;
        link_waddr = head_rd_q;
        link_wdata = {free_vld_q, free_idx_q};
        free_vld_d = 1'b1;
        free_idx_d = head_rd_q;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[free_idx_q] <= op_q.value[SB-1:0];
    end
    if (data_ren) begin
      data_rd_q <= data_mem[head_rd_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_ren) begin
      link_rd_q <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[q_cur] <= head_wdata;
    end
    if (pt_ren) begin
      head_rd_q <= head_mem[q_new];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail_we) begin
      tail_mem[q_cur] <= free_idx_q;
    end
    if (pt_ren) begin
      tail_rd_q <= tail_mem[q_new];
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_take_o) begin
      op_q <= op_i;
    end
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_vld_q <= '0;
      free_vld_q <= 1'b1;
      free_idx_q <= '0;
      hwm_q      <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_vld_q <= head_vld_d;
      free_vld_q <= free_vld_d;
      free_idx_q <= free_idx_d;
      hwm_q      <= hwm_d;
      done_q     <= done_d;
    end
  end

`ifndef SYNTHESIS
  a_done_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(state_q) == ST_EXEC || $past(state_q) == ST_POP))
    else $error("result strobe without a finishing step");

  a_hwm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hwm_q <= HW'(SLOTS))
    else $error("high-water mark beyond slot count");

  a_empty_free_all_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !free_vld_q |-> (hwm_q == HW'(SLOTS)))
    else $error("free list empty while untouched slots remain");

  a_pop_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |=> (done_q && state_q == ST_IDLE))
    else $error("pop step did not finish");

  a_push_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && !op_q.pop) |=> done_q)
    else $error("push step did not finish");
`endif

endmodule

`default_nettype wire
